### sv/lurw_pkg.sv
package lurw_pkg;

    localparam int CH_W       = 7;
    localparam int LEN_W      = 8;
    localparam int RING_AW    = 7;
    localparam int RING_DEPTH = 1 << RING_AW;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 2 * LEN_W;

    typedef logic [CH_W-1:0]    t_ch;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [RING_AW-1:0] t_ridx;

endpackage

### sv/longest_unique_run_window.sv
// Longest repeat-free run over a character stream.
//
// Input channel (i_s_axis_*): one transaction per character. tdata[6:0] holds
// the character code, tlast marks the final character of a string. Output
// channel (o_m_axis_*): one transaction per character, carrying the length of
// the repeat-free window that ends at that character and the longest such
// length seen so far in the string.
//
// A character that is new to the window is appended in S_CHK and its result
// is loaded into the output register in S_WAIT. A character that repeats goes
// from S_CHK through S_DROP, once per character dropped from the window start
// with one ring read each, then S_APPEND and S_WAIT. The next character is
// accepted in the cycle its predecessor's result is loaded, so a new character
// is taken only once the one before it is through.
//
// Reset clears the window, the best length and the per-code valid flags at
// once, and so does loading the result of a tlast character. When the receiver
// stalls, one result waits in the output register while the next character is
// processed; the block then holds its next result and stops accepting until
// the register frees up.
module longest_unique_run_window #(
    parameter int ALPHABET = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata fields from bit 0: ch [6:0], zero pad [7].
    input  logic [lurw_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    // Output stream.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata fields from bit 0: window_len [7:0], best_len [15:8].
    output logic [lurw_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);

    import lurw_pkg::*;

    localparam int CW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    // The window holds distinct codes, so it can never be longer than this.
    localparam int MAX_WIN = (ALPHABET < RING_DEPTH) ? ALPHABET : RING_DEPTH;

    typedef logic [CW-1:0] t_code;
    typedef t_code t_code_tab [RING_DEPTH];

    // Folds an incoming character into the alphabet; an identity map when the
    // alphabet covers all character codes.
    function automatic t_code_tab f_build_code_tab();
        t_code_tab tab;
        for (int i = 0; i < RING_DEPTH; i++) begin
            tab[i] = t_code'(i % ALPHABET);
        end
        return tab;
    endfunction

    localparam t_code_tab CODE_TAB = f_build_code_tab();

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_DROP,
        S_APPEND,
        S_WAIT
    } t_state;

    t_state              r_state, n_state;
    t_code               r_code;
    logic                r_last;
    t_ridx               r_head, n_head;
    t_len                r_len, n_len;
    t_len                r_best, n_best;
    logic [ALPHABET-1:0] r_valid;
    logic                r_out_valid;
    t_len                r_out_len;
    t_len                r_out_best;

    // Presence memory: one bit per code, qualified by the valid flags.
    logic                pres_mem [ALPHABET];
    logic                r_pres_q;
    logic                pres_re;
    logic                pres_we;
    t_code               pres_waddr;
    logic                pres_wdata;

    // Window ring: the codes now in the window, in arrival order.
    t_code               ring_mem [RING_DEPTH];
    t_code               r_ring_q;
    logic                ring_re;
    t_ridx               ring_raddr;
    logic                ring_we;

    logic                s_fire;
    logic                out_free;
    logic                do_append;
    logic                do_load;
    logic                hit;
    t_code               in_code;
    t_len                app_len;

    assign in_code  = CODE_TAB[i_s_axis_tdata[CH_W-1:0]];
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) || ((r_state == S_WAIT) && out_free);
    assign s_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign hit      = r_pres_q && r_valid[r_code];
    assign app_len  = r_len + t_len'(1);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_len      = r_len;
        n_best     = r_best;
        pres_re    = s_fire;
        pres_we    = 1'b0;
        pres_waddr = r_code;
        pres_wdata = 1'b0;
        ring_re    = 1'b0;
        ring_raddr = r_head;
        ring_we    = 1'b0;
        do_append  = 1'b0;
        do_load    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (hit) begin
                    ring_re = 1'b1;
                    n_state = S_DROP;
                end else begin
                    do_append = 1'b1;
                end
            end
            S_DROP: begin
                // Remove the oldest window character.
                pres_we    = 1'b1;
                pres_waddr = r_ring_q;
                pres_wdata = 1'b0;
                n_head     = r_head + t_ridx'(1);
                n_len      = r_len - t_len'(1);
                if ((r_ring_q == r_code) || (r_len <= t_len'(1))) begin
                    n_state = S_APPEND;
                end else begin
                    ring_re    = 1'b1;
                    ring_raddr = r_head + t_ridx'(1);
                end
            end
            S_APPEND: begin
                do_append = 1'b1;
            end
            S_WAIT: begin
                if (out_free) begin
                    do_load = 1'b1;
                    if (r_last) begin
                        n_head = '0;
                        n_len  = '0;
                        n_best = '0;
                    end
                    n_state = s_fire ? S_CHK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_append) begin
            ring_we    = 1'b1;
            pres_we    = 1'b1;
            pres_waddr = r_code;
            pres_wdata = 1'b1;
            n_len      = app_len;
            n_best     = (app_len > r_best) ? app_len : r_best;
            n_state    = S_WAIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_len       <= '0;
            r_best      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_len   <= n_len;
            r_best  <= n_best;
            if (do_load && r_last) begin
                r_valid <= '0;
            end else if (do_append) begin
                r_valid[r_code] <= 1'b1;
            end
            if (do_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (s_fire) begin
            r_code <= in_code;
            r_last <= i_s_axis_tlast;
        end
        if (do_load) begin
            r_out_len  <= r_len;
            r_out_best <= r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pres_we) begin
            pres_mem[pres_waddr] <= pres_wdata;
        end
        if (pres_re) begin
            r_pres_q <= pres_mem[in_code];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[r_head + r_len[RING_AW-1:0]] <= r_code;
        end
        if (ring_re) begin
            r_ring_q <= ring_mem[ring_raddr];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_best, r_out_len};

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= t_len'(MAX_WIN))
        else $error("window length exceeds the number of distinct codes");

    a_best_ge_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best >= r_len)
        else $error("best length fell below the current window length");

    a_drop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DROP) |-> (r_len != '0))
        else $error("drop step on an empty window");

    a_load_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_load |-> (r_len != '0))
        else $error("result loaded with an empty window");
`endif

endmodule

### test/run_length_checker.sv
module run_length_checker #(
    parameter int ALPHABET = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Character channel as seen on the block's input port.
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // tdata fields from bit 0: ch [6:0], zero pad [7].
    input  logic [lurw_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tlast,
    // Result channel as seen on the block's output port.
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // tdata fields from bit 0: window_len [7:0], best_len [15:8].
    input  logic [lurw_pkg::M_TDATA_W-1:0]  i_m_tdata,
    output int                              o_mismatches,
    output int                              o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import lurw_pkg::*;

    // Packed so that the layout matches the result tdata.
    typedef struct packed {
        t_len best_len;
        t_len window_len;
    } t_lens;

    logic  in_window [ALPHABET];
    t_ch   ring [RING_DEPTH];
    t_ridx head;
    t_len  run_len;
    t_len  best_run;
    t_lens expected_lens [$];

    function automatic void clear_window();
        for (int i = 0; i < ALPHABET; i++) begin
            in_window[i] = 1'b0;
        end
        head     = '0;
        run_len  = '0;
        best_run = '0;
    endfunction

    // Moves the window over one character and returns the lengths it reports.
    function automatic t_lens advance_window(input t_ch ch, input logic last);
        int    code;
        int    gone;
        logic  dropped;
        t_lens lens;
        code = int'(ch) % ALPHABET;
        if (in_window[code]) begin
            // Drop from the window start up to and including the earlier copy.
            dropped = 1'b0;
            while (run_len != 0 && !dropped) begin
                gone = int'(ring[head]) % ALPHABET;
                in_window[gone] = 1'b0;
                head    = head + 1'b1;
                run_len = run_len - 1'b1;
                dropped = (gone == code);
            end
            in_window[code] = 1'b0;
        end
        if (run_len < RING_DEPTH) begin
            ring[t_ridx'(head + run_len)] = t_ch'(code);
            in_window[code] = 1'b1;
            run_len = run_len + 1'b1;
        end
        if (run_len > best_run) begin
            best_run = run_len;
        end
        lens.window_len = run_len;
        lens.best_len   = best_run;
        if (last) begin
            clear_window();
        end
        return lens;
    endfunction

    always @(posedge i_clk) begin : watch
        t_lens got;
        t_lens want;
        if (!i_rst_n) begin
            clear_window();
            expected_lens.delete();
            o_mismatches = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                expected_lens.push_back(advance_window(i_s_tdata[CH_W-1:0], i_s_tlast));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (expected_lens.size() == 0) begin
                    $error("result without a pending character: window_len %0d, best_len %0d",
                           got.window_len, got.best_len);
                    o_mismatches++;
                end else begin
                    want = expected_lens.pop_front();
                    if (got.window_len !== want.window_len) begin
                        $error("window_len mismatch: expected %0d, actual %0d",
                               want.window_len, got.window_len);
                        o_mismatches++;
                    end
                    if (got.best_len !== want.best_len) begin
                        $error("best_len mismatch: expected %0d, actual %0d",
                               want.best_len, got.best_len);
                        o_mismatches++;
                    end
                end
            end
        end
        o_outstanding = expected_lens.size();
    end

endmodule

### test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lurw_pkg::*;

    localparam int ALPHABET       = 128;
    // Worst case is roughly 1700 characters that each drop a full window
    // plus the longest gap and stall, so this leaves a wide margin over any
    // correct run.
    localparam int LIMIT_CYCLES   = 1_000_000;
    localparam int HOLDOFF_CYCLES = 600;
    localparam int CHAR_TARGET    = 1700;
    // From this many characters on, both sides run without idling.
    localparam int QUIET_FROM     = 1450;
    localparam int HOLDOFF_AT     = 500;
    // Time to watch for stray results once no result is owed.
    localparam int DRAIN_CYCLES   = 300;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // tdata fields from bit 0: ch [6:0], zero pad [7].
    logic [S_TDATA_W-1:0]  i_s_axis_tdata;
    logic                  i_s_axis_tlast;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // tdata fields from bit 0: window_len [7:0], best_len [15:8].
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;

    int mismatches;
    int outstanding;
    int chars_sent;

    // Idling controls shared between the character sender and the receiver.
    bit tx_idle_en;
    bit rx_idle_en;
    bit holdoff_req;
    bit holdoff_done;

    // Directed strings, one entry per character: bit 7 flags the last
    // character of a string, bits 6:0 hold the code. They cover a lone
    // character at each end of the code range, an immediate repeat, a
    // repeat that drops several characters, and a repeat that drops only
    // part of the window while the best length stays ahead.
    logic [7:0] directed_script [19] = '{
        8'h80,
        8'hFF,
        8'h05, 8'h05, 8'h85,
        8'h01, 8'h02, 8'h03, 8'h01, 8'h02, 8'h03, 8'h02, 8'h82,
        8'h70, 8'h77, 8'h77, 8'h6B, 8'h65, 8'hF7
    };

    longest_unique_run_window #(
        .ALPHABET (ALPHABET)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // The checker watches both channels, predicts every result and counts
    // mismatches. It also reports how many results are still owed.
    run_length_checker #(
        .ALPHABET (ALPHABET)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_axis_tvalid),
        .i_s_tready    (o_s_axis_tready),
        .i_s_tdata     (i_s_axis_tdata),
        .i_s_tlast     (i_s_axis_tlast),
        .i_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .i_m_tdata     (o_m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("longest_unique_run_window regression: fail");
        $finish;
    end

    // Offers one character. An optional idle burst comes first, then the
    // transaction is held until the block accepts it at a rising edge.
    task automatic send_char(input t_ch ch, input logic last);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, ch};
        i_s_axis_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        chars_sent++;
        // Ask for the long receiver hold-off once, while characters keep
        // coming, so the block fills up and has to stall its input.
        if (chars_sent == HOLDOFF_AT) begin
            holdoff_req = 1'b1;
        end
    endtask

    task automatic send_string(input t_ch text [$]);
        for (int i = 0; i < text.size(); i++) begin
            send_char(text[i], i == text.size() - 1);
        end
    endtask

    // Receiver: random stall bursts, plus the single long hold-off, counted
    // in cycles here rather than by the sender.
    initial begin : receiver
        int stall;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (holdoff_req && !holdoff_done) begin
                holdoff_done = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(negedge i_clk);
            end else if (rx_idle_en && $urandom_range(0, 6) == 0) begin
                stall = $urandom_range(1, 11);
                i_m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_ch text [$];
        t_ch pool [RING_DEPTH];
        t_ch swap;
        int  kind;
        int  len;
        int  span;
        int  base;
        int  pick;
        int  full_runs;
        int  strings_done;
        bit  quiet;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        tx_idle_en      = 1'b1;
        rx_idle_en      = 1'b1;
        holdoff_req     = 1'b0;
        holdoff_done    = 1'b0;
        chars_sent      = 0;
        full_runs       = 0;
        strings_done    = 0;
        quiet           = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_script[i]) begin
            send_char(directed_script[i][CH_W-1:0], directed_script[i][7]);
        end

        while (chars_sent < CHAR_TARGET) begin
            // Some strings run with idling on one side only or none at all,
            // and the tail of the run has no idling anywhere.
            quiet      = (chars_sent >= QUIET_FROM);
            tx_idle_en = !quiet && ($urandom_range(0, 3) != 0);
            rx_idle_en = !quiet && ($urandom_range(0, 3) != 0);

            text.delete();
            for (int i = 0; i < RING_DEPTH; i++) begin
                pool[i] = t_ch'(i);
            end
            for (int i = RING_DEPTH - 1; i > 0; i--) begin
                pick       = $urandom_range(0, i);
                swap       = pool[i];
                pool[i]    = pool[pick];
                pool[pick] = swap;
            end

            if (strings_done % 25 == 0 && full_runs < 3) begin
                kind = 0;
            end else begin
                kind = $urandom_range(1, 9);
            end

            case (kind)
                0: begin
                    // Every code once, so the window reaches its full size,
                    // then a repeat that drops the whole window, only its
                    // first character, or somewhere in between.
                    full_runs++;
                    for (int i = 0; i < RING_DEPTH; i++) begin
                        text.push_back(pool[i]);
                    end
                    case (full_runs)
                        1:       text.push_back(pool[RING_DEPTH - 1]);
                        2:       text.push_back(pool[0]);
                        default: text.push_back(pool[$urandom_range(0, RING_DEPTH - 1)]);
                    endcase
                end
                1, 2, 3, 4: begin
                    // Small alphabet: frequent repeats with short drops.
                    base = $urandom_range(0, 127);
                    span = $urandom_range(1, 8);
                    len  = $urandom_range(1, 40);
                    for (int i = 0; i < len; i++) begin
                        text.push_back(t_ch'(base + $urandom_range(0, span - 1)));
                    end
                end
                5, 6: begin
                    // A distinct run followed by repeats from inside it,
                    // which drop windows of varied depth.
                    len = $urandom_range(1, 50);
                    for (int i = 0; i < len; i++) begin
                        text.push_back(pool[i]);
                    end
                    for (int i = $urandom_range(1, 6); i > 0; i--) begin
                        text.push_back(pool[$urandom_range(0, len - 1)]);
                    end
                end
                default: begin
                    len = $urandom_range(1, 60);
                    for (int i = 0; i < len; i++) begin
                        text.push_back(t_ch'($urandom_range(0, 127)));
                    end
                end
            endcase

            send_string(text);
            strings_done++;
        end

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tlast  <= 1'b0;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;

        // Wait for every owed result, then watch a while for strays.
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("longest_unique_run_window regression: pass");
        end else begin
            $display("longest_unique_run_window regression: fail");
        end
        $finish;
    end

endmodule
